// ===== rtl/cde_pkg.sv =====
package cde_pkg;

	// Operation codes carried by a request
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	// Status codes returned with every response
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam int WordW = 32;
	localparam int OccW  = 8;

	typedef logic signed [WordW-1:0] word_t;

	typedef struct packed {
		op_t   op;
		word_t data_item;
	} req_t;

	typedef struct packed {
		status_t         status;
		word_t           removed_item;
		word_t           front_item;
		word_t           rear_item;
		logic [OccW-1:0] occupancy;
	} rsp_t;

	// What every cell of a chain does at a clock edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN,
		CELL_WRITE_END
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		word_t      word;
	} cell_ctl_t;

endpackage

// ===== rtl/cde_cell.sv =====
// Chain cell: holds one word, takes a neighbour's on a shift or ctl.word when sel
module cde_cell (
	input  logic              clk,
	input  cde_pkg::cell_ctl_t ctl,
	input  logic              sel,
	input  cde_pkg::word_t    below,
	input  cde_pkg::word_t    above,
	output cde_pkg::word_t    word_q
);

	cde_pkg::word_t word_d;

	// next word
	always_comb begin
		unique case (ctl.mode)
			cde_pkg::CELL_HOLD:       word_d = word_q;
			cde_pkg::CELL_SHIFT_UP:   word_d = below;
			cde_pkg::CELL_SHIFT_DOWN: word_d = above;
			cde_pkg::CELL_WRITE_END:  word_d = sel ? ctl.word : word_q;
			default:                  word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

endmodule

// ===== rtl/cde_chain.sv =====
// Row of cells with one end pinned at cell 0; new words enter there or at the
// first free cell, marked by the occupancy count
module cde_chain #(
	parameter int DEPTH = 128,
	localparam int CntW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  cde_pkg::cell_ctl_t ctl,
	input  logic [CntW-1:0]    count,
	output cde_pkg::word_t     first,
	output cde_pkg::word_t     second
);

	cde_pkg::word_t cell_word[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cde_pkg::word_t below;
		cde_pkg::word_t above;

		// cell 0 takes the incoming word on a shift up; the last cell keeps its own
		if (i == 0) begin : g_lo
			assign below = ctl.word;
		end else begin : g_mid_lo
			assign below = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi
			assign above = cell_word[i];
		end else begin : g_mid_hi
			assign above = cell_word[i+1];
		end

		cde_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.sel    (count == CntW'(i)),
			.below  (below),
			.above  (above),
			.word_q (cell_word[i])
		);
	end

	assign first  = cell_word[0];
	assign second = cell_word[1];

endmodule

// ===== rtl/circular_deque_engine_top.sv =====
// Double-ended queue engine: one request per cycle unless the response stalls, and a
// registered response. Two chains of DEPTH cells, one front-, one rear-aligned, hold
// the entries with both ends in fixed cells; a push updates both chains, a pop one.
// A registered response stage lets a new request transfer while rsp_ready is high.
// Reset clears the occupancy count and the response valid; stored words stay undefined.
module circular_deque_engine_top #(
	parameter int DEPTH = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cde_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cde_pkg::rsp_t rsp
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0]    count_q;
	logic [CntW-1:0]    count_d;
	logic               rsp_valid_q;
	cde_pkg::rsp_t      rsp_q;
	cde_pkg::rsp_t      rsp_d;
	cde_pkg::cell_ctl_t front_ctl;
	cde_pkg::cell_ctl_t rear_ctl;
	cde_pkg::word_t     front_first;
	cde_pkg::word_t     front_second;
	cde_pkg::word_t     rear_first;
	cde_pkg::word_t     rear_second;
	logic               xfer;
	logic               is_empty;
	logic               is_full;
	logic               is_single;
	logic               ok;
	logic [CntW+7:0]    count_ext;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign xfer      = req_valid && req_ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CntW'(DEPTH));
	assign is_single = (count_q == CntW'(1));

	// operation decode: chain controls and the response
	always_comb begin
		front_ctl.mode = cde_pkg::CELL_HOLD;
		front_ctl.word = req.data_item;
		rear_ctl.mode  = cde_pkg::CELL_HOLD;
		rear_ctl.word  = req.data_item;
		count_d        = count_q;
		ok             = 1'b0;
		rsp_d          = rsp_q;
		rsp_d.status       = cde_pkg::ST_DONE;
		rsp_d.removed_item = '0;
		rsp_d.front_item   = front_first;
		rsp_d.rear_item    = rear_first;
		unique case (req.op)
			cde_pkg::OP_PUSH_FRONT: begin
				ok = !is_full;
				front_ctl.mode   = cde_pkg::CELL_SHIFT_UP;
				rear_ctl.mode    = cde_pkg::CELL_WRITE_END;
				count_d          = count_q + CntW'(1);
				rsp_d.front_item = req.data_item;
				if (is_empty) begin
					rsp_d.rear_item = req.data_item;
				end
				if (is_full) begin
					rsp_d.status = cde_pkg::ST_OVERFLOW;
				end
			end
			cde_pkg::OP_PUSH_REAR: begin
				ok = !is_full;
				front_ctl.mode  = cde_pkg::CELL_WRITE_END;
				rear_ctl.mode   = cde_pkg::CELL_SHIFT_UP;
				count_d         = count_q + CntW'(1);
				rsp_d.rear_item = req.data_item;
				if (is_empty) begin
					rsp_d.front_item = req.data_item;
				end
				if (is_full) begin
					rsp_d.status = cde_pkg::ST_OVERFLOW;
				end
			end
			cde_pkg::OP_POP_FRONT: begin
				ok = !is_empty;
				front_ctl.mode     = cde_pkg::CELL_SHIFT_DOWN;
				count_d            = count_q - CntW'(1);
				rsp_d.removed_item = front_first;
				rsp_d.front_item   = front_second;
				if (is_empty) begin
					rsp_d.status = cde_pkg::ST_UNDERFLOW;
				end
			end
			cde_pkg::OP_POP_REAR: begin
				ok = !is_empty;
				rear_ctl.mode      = cde_pkg::CELL_SHIFT_DOWN;
				count_d            = count_q - CntW'(1);
				rsp_d.removed_item = rear_first;
				rsp_d.rear_item    = rear_second;
				if (is_empty) begin
					rsp_d.status = cde_pkg::ST_UNDERFLOW;
				end
			end
			default: ok = 1'b0;
		endcase

		// a failed operation changes nothing
		if (!ok || !xfer) begin
			front_ctl.mode = cde_pkg::CELL_HOLD;
			rear_ctl.mode  = cde_pkg::CELL_HOLD;
			count_d        = count_q;
		end
		if (!ok) begin
			rsp_d.removed_item = '0;
			rsp_d.front_item   = front_first;
			rsp_d.rear_item    = rear_first;
		end

		// a queue that is empty after the step shows zero at both ends
		if ((!ok && is_empty) || (ok && is_single &&
				(req.op == cde_pkg::OP_POP_FRONT || req.op == cde_pkg::OP_POP_REAR))) begin
			rsp_d.front_item = '0;
			rsp_d.rear_item  = '0;
		end

		// occupancy after the step, low eight bits
		count_ext       = {8'd0, count_d};
		rsp_d.occupancy = count_ext[7:0];
	end

	cde_chain #(.DEPTH(DEPTH)) u_front_chain (
		.clk    (clk),
		.ctl    (front_ctl),
		.count  (count_q),
		.first  (front_first),
		.second (front_second)
	);

	cde_chain #(.DEPTH(DEPTH)) u_rear_chain (
		.clk    (clk),
		.ctl    (rear_ctl),
		.count  (count_q),
		.first  (rear_first),
		.second (rear_second)
	);

	// occupancy and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (req_ready) begin
				rsp_valid_q <= req_valid;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (xfer) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/deque_result_checker.sv =====
module deque_result_checker #(
	parameter int DEPTH = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  cde_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  cde_pkg::rsp_t rsp,
	output int            fail_count,
	output int            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import cde_pkg::*;

	// Shadow copy of the queue contents, front at index 0
	word_t held_words[$];
	// Responses owed by the block, oldest first
	rsp_t  owed_rsps[$];
	rsp_t  want;

	// Apply one request to the shadow queue and work out its response
	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		res = '0;
		res.status = ST_DONE;
		case (r.op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (held_words.size() >= DEPTH)
					res.status = ST_OVERFLOW;
				else if (r.op == OP_PUSH_FRONT)
					held_words.push_front(r.data_item);
				else
					held_words.push_back(r.data_item);
			end
			default: begin
				if (held_words.size() == 0)
					res.status = ST_UNDERFLOW;
				else if (r.op == OP_POP_FRONT)
					res.removed_item = held_words.pop_front();
				else
					res.removed_item = held_words.pop_back();
			end
		endcase
		if (held_words.size() != 0) begin
			res.front_item = held_words[0];
			res.rear_item  = held_words[held_words.size()-1];
		end
		res.occupancy = OccW'(held_words.size());
		return res;
	endfunction

	task automatic report_field(input string field, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
		end
	endtask

	// Predict on each request transfer, compare on each response transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				owed_rsps.push_back(apply_request(req));
			if (rsp_valid && rsp_ready) begin
				if (owed_rsps.size() == 0) begin
					fail_count++;
					$display("%0t: response with nothing owed, got %h", $time, rsp);
				end else begin
					want = owed_rsps.pop_front();
					report_field("status", want.status, rsp.status);
					report_field("removed_item", want.removed_item, rsp.removed_item);
					report_field("front_item", want.front_item, rsp.front_item);
					report_field("rear_item", want.rear_item, rsp.rear_item);
					report_field("occupancy", want.occupancy, rsp.occupancy);
				end
			end
			outstanding = owed_rsps.size();
		end
	end

endmodule

// ===== tb/circular_deque_engine_top_tb.sv =====
module circular_deque_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cde_pkg::*;

	localparam int DEPTH = 128;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	int   fail_count;
	int   outstanding;

	circular_deque_engine_top #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	deque_result_checker #(.DEPTH(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// Receiver back-pressure: short and long stalls, with calm stretches
	initial begin
		int stall_left;
		int calm_left;
		bit calm;
		int r;
		stall_left = 0;
		calm_left  = 0;
		calm       = 1'b0;
		rsp_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (calm_left == 0) begin
				calm      = ($urandom_range(3) == 0);
				calm_left = $urandom_range(100, 300);
			end else
				calm_left--;
			if (stall_left > 0) begin
				rsp_ready = 1'b0;
				stall_left--;
			end else if (calm) begin
				rsp_ready = 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					rsp_ready = 1'b1;
				end else begin
					rsp_ready  = 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
				end
			end
		end
	end

	// One request transfer; valid held with a stable payload until taken
	task automatic send_req(input op_t op, input word_t data);
		@(negedge clk);
		req_valid     = 1'b1;
		req.op        = op;
		req.data_item = data;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			req_valid = 1'b0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A segment biased towards pushes or pops, random ends and words
	task automatic run_segment(input int n_items, input int push_pct, input bit busy);
		op_t op;
		repeat (n_items) begin
			if ($urandom_range(99) < push_pct)
				op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
			else
				op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
			send_req(op, $urandom);
			if (!busy)
				idle_cycles(pick_gap());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_cycles(2);

		// Underflow at both ends of an empty queue
		send_req(OP_POP_FRONT, 32'sh1234_5678);
		send_req(OP_POP_REAR, -32'sd1);
		// First push into empty from the front, then extremes at both ends
		send_req(OP_PUSH_FRONT, 32'sh8000_0000);
		send_req(OP_PUSH_REAR, 32'sh7FFF_FFFF);
		send_req(OP_PUSH_FRONT, -32'sd1);
		send_req(OP_PUSH_REAR, 32'sd0);
		idle_cycles(3);
		send_req(OP_PUSH_FRONT, 32'sd1);
		send_req(OP_POP_FRONT, 32'sd0);
		send_req(OP_POP_REAR, 32'sd0);
		send_req(OP_POP_FRONT, 32'sd0);
		send_req(OP_POP_REAR, 32'sd0);
		// Last entry popped leaves the queue empty
		send_req(OP_POP_FRONT, 32'sd0);
		send_req(OP_POP_REAR, 32'sd0);
		// First push into empty from the rear, popped from the front
		send_req(OP_PUSH_REAR, 32'sh5555_5555);
		send_req(OP_POP_FRONT, 32'sd0);
		send_req(OP_PUSH_FRONT, 32'shAAAA_AAAA);
		send_req(OP_POP_REAR, 32'sd0);
		send_req(OP_POP_FRONT, 32'sh0F0F_0F0F);

		// Hold off until every owed response has come back
		idle_cycles(1);
		while (outstanding != 0)
			@(negedge clk);

		// Fill past full, drain past empty, then mixed traffic; twice over
		repeat (2) begin
			run_segment(200, 90, 1'($urandom_range(1)));
			run_segment(200, 10, 1'($urandom_range(1)));
			run_segment(75, 50, 1'($urandom_range(1)));
		end
		idle_cycles(1);

		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cde_pkg.sv
rtl/cde_cell.sv
rtl/cde_chain.sv
rtl/circular_deque_engine_top.sv
tb/deque_result_checker.sv
tb/circular_deque_engine_top_tb.sv
